### hdl/pcx_pkg.sv
// ---------------------------------------------------------------------------
// pcx_pkg: shared types and constants for the PCX run-length encoder
// Request payloads, run descriptors and the front-to-back queue entry.
// ---------------------------------------------------------------------------
package pcx_pkg;

    localparam logic [5:0] RUN_LIMIT   = 6'd63;
    localparam logic [1:0] MARK_BITS   = 2'b11;
    localparam int         QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       item_last;
        logic       line_done;
    } t_out_item;

    typedef struct packed {
        logic [7:0] value;
        logic [5:0] count;
    } t_run;

    // One input request turns into at most two closed runs: the run it ends
    // (or the 63 cut) and the line-end flush.
    typedef struct packed {
        logic a_vld;
        t_run run_a;
        logic b_vld;
        t_run run_b;
        logic eol;
    } t_entry;

endpackage

### hdl/pcx_front.sv
// ---------------------------------------------------------------------------
// pcx_front: run tracker
// Accepts raw bytes, keeps the pending run and hands closed runs to the queue.
// ---------------------------------------------------------------------------
module pcx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcx_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_q_push,
    output pcx_pkg::t_entry   o_q_entry
);

    logic [7:0] r_held, n_held;
    logic [5:0] r_count, n_count;
    logic       accept;
    logic [5:0] cnt_mid;
    logic [7:0] held_mid;
    pcx_pkg::t_entry entry;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    always_comb begin
        entry          = '0;
        entry.eol      = i_item.line_end;
        held_mid       = r_held;
        cnt_mid        = r_count;
        entry.run_a    = '{value: r_held, count: r_count};
        if (r_count == '0) begin
            held_mid = i_item.data_byte;
            cnt_mid  = 6'd1;
        end else if (i_item.data_byte == r_held) begin
            cnt_mid = r_count + 6'd1;
            if (cnt_mid == pcx_pkg::RUN_LIMIT) begin
                entry.a_vld       = 1'b1;
                entry.run_a.count = pcx_pkg::RUN_LIMIT;
                cnt_mid           = '0;
            end
        end else begin
            entry.a_vld = 1'b1;
            held_mid    = i_item.data_byte;
            cnt_mid     = 6'd1;
        end

        entry.run_b = '{value: held_mid, count: cnt_mid};
        n_held      = held_mid;
        n_count     = cnt_mid;
        if (i_item.line_end) begin
            entry.b_vld = (cnt_mid != '0);
            n_count     = '0;
        end
    end

    assign o_q_push  = accept && (entry.a_vld || entry.b_vld);
    assign o_q_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

### hdl/pcx_queue.sv
// ---------------------------------------------------------------------------
// pcx_queue: small FIFO of closed-run entries
// Decouples the run tracker from the byte emitter.
// ---------------------------------------------------------------------------
module pcx_queue #(
    parameter int DEPTH = pcx_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcx_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pcx_pkg::t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcx_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### hdl/pcx_back.sv
// ---------------------------------------------------------------------------
// pcx_back: byte emitter
// Expands each queued entry into literal, marker and value bytes, one per
// cycle while the result slot is free or being popped, into a registered result slot.
// ---------------------------------------------------------------------------
module pcx_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  pcx_pkg::t_entry    i_head,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output pcx_pkg::t_out_item o_item
);

    logic r_half, n_half;   // 0: run a, 1: run b
    logic r_sub, n_sub;     // 0: first byte of the run, 1: second
    logic r_ovld, n_ovld;
    pcx_pkg::t_out_item r_out;
    pcx_pkg::t_out_item n_out;

    logic         slot_free, step, use_b, need_mark, run_last, entry_last;
    pcx_pkg::t_run cur;

    assign slot_free = !r_ovld || i_pop;
    assign step      = slot_free && !i_q_empty;
    assign use_b     = r_half || !i_head.a_vld;
    assign cur       = use_b ? i_head.run_b : i_head.run_a;
    // single bytes that look like a marker still need a count in front
    assign need_mark = (cur.count != 6'd1) || (cur.value[7:6] == pcx_pkg::MARK_BITS);
    assign run_last  = !need_mark || r_sub;
    assign entry_last = run_last && (use_b || !i_head.b_vld);

    always_comb begin
        n_half = r_half;
        n_sub  = r_sub;
        n_ovld = r_ovld && !i_pop;
        n_out  = r_out;
        if (step) begin
            n_ovld          = 1'b1;
            n_out.code_byte = (need_mark && !r_sub) ? {pcx_pkg::MARK_BITS, cur.count}
                                                    : cur.value;
            n_out.item_last = entry_last;
            n_out.line_done = entry_last && i_head.eol;
            if (entry_last) begin
                n_half = 1'b0;
                n_sub  = 1'b0;
            end else if (run_last) begin
                n_half = 1'b1;
                n_sub  = 1'b0;
            end else begin
                n_sub = 1'b1;
            end
        end
    end

    assign o_q_pop = step && entry_last;
    assign o_empty = !r_ovld;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
            r_sub  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_half <= n_half;
            r_sub  <= n_sub;
            r_ovld <= n_ovld;
        end
    end

endmodule

### hdl/pcx_rle_encoder_top.sv
// ---------------------------------------------------------------------------
// pcx_rle_encoder_top: PCX-style run-length encoder
// Raw bytes in, encoded bytes out, both sides as queues.
// ---------------------------------------------------------------------------
// A raw byte request is taken in the cycle it is pushed whenever the internal
// run queue (QUEUE_DEPTH entries) has room; bytes that only extend a run
// occupy no queue entry. Encoded bytes leave one per cycle from a registered
// slot while results are popped, so the result port sets the pace: a
// request that closes a run yields one or two code bytes, and a line end
// after a run change up to four. The first result of a request passes
// through the run queue and the registered result slot.
// Every line ends with exactly one result flagged line_done.
module pcx_rle_encoder_top #(
    parameter int QUEUE_DEPTH = pcx_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pcx_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output pcx_pkg::t_out_item o_out_item
);

    logic            q_push, q_pop, q_full, q_empty;
    pcx_pkg::t_entry q_in, q_head;

    pcx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_in_item),
        .i_q_full  (q_full),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_entry (q_in)
    );

    pcx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pcx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for pcx_rle_encoder_top
// Pushes raw bytes in line-shaped runs plus some random noise, predicts the
// encoded byte stream in a scoreboard, and checks every popped code byte.
// Both queue sides idle at random.
// ---------------------------------------------------------------------------
module tb;

    localparam int RAND_REQUESTS = 340;
    localparam int DRAIN_CYCLES  = 16;

    // Holds the expected code bytes and a private copy of the run state.
    class rle_scoreboard;
        pcx_pkg::t_out_item code_queue[$];
        pcx_pkg::t_out_item fresh[$];
        logic [7:0] run_byte;
        logic [5:0] run_len;
        int         mismatches;

        function new();
            run_byte   = '0;
            run_len    = '0;
            mismatches = 0;
        endfunction

        function void push_code(logic [7:0] v);
            pcx_pkg::t_out_item c;
            c.code_byte = v;
            c.item_last = 1'b0;
            c.line_done = 1'b0;
            fresh.push_back(c);
        endfunction

        function void close_run(logic [7:0] v, logic [5:0] n);
            if (n == 0)
                return;
            if (n == 1 && v[7:6] != pcx_pkg::MARK_BITS) begin
                push_code(v);
            end else begin
                push_code({pcx_pkg::MARK_BITS, n});
                push_code(v);
            end
        endfunction

        function void note_request(pcx_pkg::t_in_item req);
            fresh.delete();
            if (run_len == 0) begin
                run_byte = req.data_byte;
                run_len  = 6'd1;
            end else if (req.data_byte == run_byte) begin
                run_len = run_len + 6'd1;
                // run cut at the limit: marker 0xFF plus the byte
                if (run_len >= pcx_pkg::RUN_LIMIT) begin
                    close_run(run_byte, pcx_pkg::RUN_LIMIT);
                    run_len = '0;
                end
            end else begin
                close_run(run_byte, run_len);
                run_byte = req.data_byte;
                run_len  = 6'd1;
            end
            if (req.line_end) begin
                close_run(run_byte, run_len);
                run_len = '0;
            end
            if (fresh.size() > 0) begin
                fresh[fresh.size()-1].item_last = 1'b1;
                fresh[fresh.size()-1].line_done = req.line_end;
            end
            foreach (fresh[i])
                code_queue.push_back(fresh[i]);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: MISMATCH %s", $realtime, msg);
        endfunction

        function void check_result(pcx_pkg::t_out_item got);
            pcx_pkg::t_out_item want;
            if (code_queue.size() == 0) begin
                flag($sformatf("unexpected code byte %02h last %0b done %0b",
                               got.code_byte, got.item_last, got.line_done));
                return;
            end
            want = code_queue.pop_front();
            if (got.code_byte !== want.code_byte || got.item_last !== want.item_last ||
                got.line_done !== want.line_done)
                flag($sformatf("exp byte %02h last %0b done %0b, got byte %02h last %0b done %0b",
                               want.code_byte, want.item_last, want.line_done,
                               got.code_byte, got.item_last, got.line_done));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    pcx_pkg::t_in_item  i_in_item;
    logic               empty;
    logic               pop;
    pcx_pkg::t_out_item o_out_item;

    rle_scoreboard sb;
    int  req_count;
    int  rand_base;
    int  pop_wait;
    bit  tx_quiet;
    bit  rx_quiet;

    pcx_rle_encoder_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(logic [7:0] b, logic eol);
        int gap;
        pcx_pkg::t_in_item req;
        req.data_byte = b;
        req.line_end  = eol;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= req;
        do
            @(posedge i_clk);
        while (full);
        sb.note_request(req);
        req_count++;
        @(negedge i_clk);
    endtask

    task automatic send_run(logic [7:0] b, int len, logic eol_at_end);
        for (int i = 0; i < len; i++)
            send_byte(b, eol_at_end && (i == len - 1));
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return {pcx_pkg::MARK_BITS, 6'($urandom_range(0, 63))};
        if (r < 55)
            return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 1;
        if (r < 80)
            return $urandom_range(2, 4);
        if (r < 93)
            return $urandom_range(5, 12);
        if (r < 98)
            return $urandom_range(60, 64);
        return $urandom_range(120, 130);
    endfunction

    // long runs are trimmed so the random phase stays near its request budget
    task automatic send_line();
        int nruns;
        int len;
        int left;
        nruns = $urandom_range(1, 6);
        for (int r = 0; r < nruns; r++) begin
            left = RAND_REQUESTS - (req_count - rand_base);
            len  = pick_run_len();
            if (len > left)
                len = (left > 0) ? left : 1;
            send_run(pick_byte(), len, r == nruns - 1);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
            send_byte(pick_byte(), $urandom_range(0, 3) == 0);
    endtask

    // result side
    initial begin
        pop      = 1'b0;
        pop_wait = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (pop_wait > 0) begin
                pop <= 1'b0;
                pop_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_out_item);
            pop_wait = pick_gap(rx_quiet);
        end
    end

    initial begin
        sb        = new();
        req_count = 0;
        rand_base = 0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        push      = 1'b0;
        i_in_item = '0;
        i_rst_n   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, literals vs. markers, four-byte line ends
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'hc0, 1'b1);
        send_byte(8'hbf, 1'b0);
        send_byte(8'h3f, 1'b0);
        send_run(8'h40, 2, 1'b1);
        send_run(8'h55, 2, 1'b0);
        send_byte(8'hc5, 1'b1);             // run change at line end
        send_run(8'h12, 2, 1'b0);
        send_run(8'h13, 2, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hfe, 1'b1);
        send_run(8'hc1, 3, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b1);

        // random: mostly well-formed lines, some noise
        rand_base = req_count;
        while (req_count - rand_base < RAND_REQUESTS) begin
            if ($urandom_range(0, 99) < 15)
                tx_quiet = ~tx_quiet;
            if ($urandom_range(0, 99) < 15)
                rx_quiet = ~rx_quiet;
            if ($urandom_range(0, 99) < 12)
                send_noise();
            else
                send_line();
        end
        // close any line left open by noise
        send_byte(pick_byte(), 1'b1);
        push <= 1'b0;

        rx_quiet = 1'b0;
        while (sb.code_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.code_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
hdl/pcx_pkg.sv
hdl/pcx_front.sv
hdl/pcx_queue.sv
hdl/pcx_back.sv
hdl/pcx_rle_encoder_top.sv
tb/tb.sv
